@@ hdl/bounded_integer_set_unit_macros.svh @@
// Assertion macros for the bounded integer set unit.
`ifndef BOUNDED_INTEGER_SET_UNIT_MACROS_SVH
`define BOUNDED_INTEGER_SET_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bounded integer set assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bounded integer set assertion failed");
`else
`define BIS_ASSERT_IMP(label, ante, cons)
`define BIS_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ hdl/bis_pkg.sv @@
// Package with the types and constants of the bounded integer set unit.
`timescale 1ns / 1ps

package bis_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [VALUE_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic               rejected;
    } t_out_res;

    typedef struct packed {
        logic load;
        logic scan;
        logic add_wr;
        logic set_rej;
        logic move_rd;
        logic move_wr;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic             match;
        logic             exhausted;
        logic             is_add;
        logic             is_remove;
        logic             full;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage

@@ hdl/bis_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bis_ctrl.sv @@
// Controller state machine of the bounded integer set unit.
`timescale 1ns / 1ps

module bis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bis_pkg::t_stat i_stat,
    output bis_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MRD  = 5'b00100,
        S_MWR  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.match) begin
                    n_state = i_stat.is_remove ? S_MRD : S_DONE;
                end else if (i_stat.exhausted) begin
                    if (i_stat.is_add) begin
                        o_cmd.add_wr  = !i_stat.full;
                        o_cmd.set_rej = i_stat.full;
                    end
                    n_state = S_DONE;
                end
            end
            S_MRD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = S_MWR;
            end
            S_MWR: begin
                o_cmd.move_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ hdl/bis_dp.sv @@
// Datapath of the bounded integer set unit: entry store, scan, count and result.
`timescale 1ns / 1ps

module bis_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bis_pkg::t_cmd               i_cmd,
    input  bis_pkg::t_in_req            i_in_req,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_valid,
    input  logic [bis_pkg::CAP_W-1:0]   i_cfg_data,
    output bis_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    output bis_pkg::t_out_res           o_out_res
);

    bis_pkg::t_in_req                  r_req;
    logic [bis_pkg::CNT_W-1:0]         r_idx;
    logic [bis_pkg::CNT_W-1:0]         n_idx;
    logic                              r_rd_vld;
    logic                              n_rd_vld;
    logic [bis_pkg::ADDR_W-1:0]        r_rd_idx;
    logic [bis_pkg::ADDR_W-1:0]        n_rd_idx;
    logic                              r_found;
    logic                              n_found;
    logic [bis_pkg::ADDR_W-1:0]        r_slot;
    logic [bis_pkg::ADDR_W-1:0]        n_slot;
    logic                              r_rej;
    logic                              n_rej;
    logic [bis_pkg::CNT_W-1:0]         r_cnt;
    logic [bis_pkg::CNT_W-1:0]         n_cnt;
    logic [bis_pkg::CAP_W-1:0]         r_cap;
    bis_pkg::t_out_res                 r_out;
    logic                              r_out_vld;
    logic                              n_out_vld;

    logic                              ram_we;
    logic [bis_pkg::ADDR_W-1:0]        ram_waddr;
    logic [bis_pkg::VALUE_W-1:0]       ram_wdata;
    logic [bis_pkg::ADDR_W-1:0]        ram_raddr;
    logic [bis_pkg::VALUE_W-1:0]       ram_rdata;
    logic [bis_pkg::CNT_W-1:0]         limit;
    logic                              match;

    bis_ram #(
        .WIDTH (bis_pkg::VALUE_W),
        .DEPTH (bis_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign limit = (32'(r_cap) > bis_pkg::DEPTH) ? bis_pkg::CNT_W'(bis_pkg::DEPTH)
                                                 : bis_pkg::CNT_W'(r_cap);
    assign match = r_rd_vld && (ram_rdata == $unsigned(r_req.value));

    always_comb begin
        ram_raddr = i_cmd.move_rd ? bis_pkg::ADDR_W'(r_cnt - 1'b1)
                                  : r_idx[bis_pkg::ADDR_W-1:0];
        ram_we    = i_cmd.add_wr || i_cmd.move_wr;
        ram_waddr = i_cmd.move_wr ? r_slot : r_cnt[bis_pkg::ADDR_W-1:0];
        ram_wdata = i_cmd.move_wr ? ram_rdata : $unsigned(r_req.value);
    end

    always_comb begin
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_found   = r_found;
        n_slot    = r_slot;
        n_rej     = r_rej;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && i_out_stall;
        if (i_cmd.load) begin
            n_idx    = '0;
            n_rd_vld = 1'b0;
            n_found  = 1'b0;
            n_slot   = '0;
            n_rej    = 1'b0;
        end
        if (i_cmd.scan) begin
            if (r_idx < r_cnt) begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx[bis_pkg::ADDR_W-1:0];
                n_idx    = r_idx + 1'b1;
            end else begin
                n_rd_vld = 1'b0;
            end
            if (match) begin
                n_found = 1'b1;
                n_slot  = r_rd_idx;
            end
        end
        if (i_cmd.add_wr) begin
            n_slot = r_cnt[bis_pkg::ADDR_W-1:0];
            n_cnt  = r_cnt + 1'b1;
        end
        if (i_cmd.set_rej) begin
            n_rej = 1'b1;
        end
        if (i_cmd.move_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
        if (i_cmd.finish) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_cnt     <= '0;
            r_cap     <= bis_pkg::CAP_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld  <= n_rd_vld;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req;
        end
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_found  <= n_found;
        r_slot   <= n_slot;
        r_rej    <= n_rej;
        if (i_cmd.finish) begin
            r_out.found    <= r_found;
            r_out.slot     <= bis_pkg::SLOT_W'(r_slot);
            r_out.count    <= bis_pkg::COUNT_W'(r_cnt);
            r_out.rejected <= r_rej;
        end
    end

    always_comb begin
        o_stat.match     = match;
        o_stat.exhausted = !r_rd_vld && (r_idx >= r_cnt);
        o_stat.is_add    = (r_req.action == bis_pkg::ACT_ADD);
        o_stat.is_remove = (r_req.action == bis_pkg::ACT_REMOVE);
        o_stat.full      = (r_cnt >= limit);
        o_stat.out_free  = !r_out_vld || !i_out_stall;
        o_stat.count     = r_cnt;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

endmodule

@@ hdl/bounded_integer_set_unit.sv @@
// Top level of the bounded integer set unit.
//
//   Channel   Direction   Handshake               Payload
//   in        request in  i_in_valid / o_in_stall   bis_pkg::t_in_req
//   out       result out  o_out_valid / i_out_stall bis_pkg::t_out_res
//   cfg       write in    i_cfg_valid / o_cfg_ready i_cfg_data (capacity)
//
// One request at a time: a request scans the stored entries until it finds its value or runs
// out of them, and a remove that finds its value then reads the last entry and writes it into
// the freed slot; the scan reads one stored entry per cycle from the RAM.
// Reset clears the count and the result valid flag, sets capacity to 16 and holds off
// requests and configuration writes.
// A waiting result does not block the next request, which stalls only once it is done.
`timescale 1ns / 1ps
`include "bounded_integer_set_unit_macros.svh"

module bounded_integer_set_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bis_pkg::t_in_req          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bis_pkg::t_out_res         o_out_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bis_pkg::CAP_W-1:0] i_cfg_data
);

    bis_pkg::t_cmd  cmd;
    bis_pkg::t_stat stat;
    logic           busy;

    bis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    bis_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    assign o_in_stall  = busy || !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    `BIS_ASSERT_IMP(a_count_bound, 1'b1, 32'(stat.count) <= bis_pkg::DEPTH)
    `BIS_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `BIS_ASSERT_IMP(a_reject_absent, o_out_valid && o_out_res.rejected, !o_out_res.found)
    `BIS_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.scan, cmd.move_rd, cmd.move_wr, cmd.finish}))

endmodule
